FILE: sv/clb_pkg.sv
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and constants of the clipped interleaved blit core.
// ----------------------------------------------------------------------------
package clb_pkg;

    localparam logic [7:0]  C_SCREEN_COLUMNS = 8'd32;
    localparam logic [7:0]  C_SCREEN_LINES   = 8'd192;
    localparam logic [15:0] C_BASE_RESET     = 16'h4000;

    typedef struct packed {
        logic             func;
        logic signed [7:0] col;
        logic [7:0]       top_line;
        logic [7:0]       width;
        logic [7:0]       height;
        logic [7:0]       source_byte;
    } t_cmd;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        last;
    } t_res;

endpackage

FILE: sv/clb_in_stage.sv
// ----------------------------------------------------------------------------
// clb_in_stage
// Input register: captures one command beat and holds it until taken.
// ----------------------------------------------------------------------------
module clb_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  clb_pkg::t_cmd i_cmd,
    input  logic          i_take,
    output logic          o_stall,
    output logic          o_vld,
    output clb_pkg::t_cmd o_cmd
);

    logic          r_vld;
    logic          n_vld;
    clb_pkg::t_cmd r_cmd;
    logic          load;

    assign o_stall = r_vld && !i_take;
    assign load    = i_valid && !o_stall;
    assign n_vld   = load || (r_vld && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_vld = r_vld;
    assign o_cmd = r_cmd;

endmodule

FILE: sv/clb_calc.sv
// ----------------------------------------------------------------------------
// clb_calc
// Column and row counters, clipping and interleaved address generation.
// ----------------------------------------------------------------------------
module clb_calc (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_adv,
    input  clb_pkg::t_cmd i_cmd,
    output clb_pkg::t_res o_res
);

    localparam logic [7:0] C_COLS  = clb_pkg::C_SCREEN_COLUMNS;
    localparam logic [7:0] C_LINES = clb_pkg::C_SCREEN_LINES;

    logic [15:0]       r_base;
    logic [7:0]        r_col_cnt;
    logic [7:0]        r_row_cnt;
    logic [7:0]        n_col_cnt;
    logic [7:0]        n_row_cnt;
    logic signed [8:0] scr_col;
    logic [7:0]        line;
    logic              visible;
    logic              row_end;
    logic              rect_end;
    logic [12:0]       offset;

    always_comb begin
        scr_col  = {i_cmd.col[7], i_cmd.col} + $signed({1'b0, r_col_cnt});
        line     = i_cmd.top_line + r_row_cnt;
        visible  = !scr_col[8] && (scr_col[7:0] < C_COLS) && (line < C_LINES);
        row_end  = ({1'b0, r_col_cnt} + 9'd1) >= {1'b0, i_cmd.width};
        rect_end = row_end && (({1'b0, r_row_cnt} + 9'd1) >= {1'b0, i_cmd.height});
        offset   = {line[7:6], line[2:0], line[5:3], scr_col[4:0]};

        o_res.write_enable = visible;
        o_res.address      = visible ? (r_base + {3'b000, offset}) : 16'd0;
        o_res.write_data   = (visible && !i_cmd.func) ? i_cmd.source_byte : 8'd0;
        o_res.last         = rect_end;

        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        if (rect_end) begin
            n_col_cnt = 8'd0;
            n_row_cnt = 8'd0;
        end else if (row_end) begin
            n_col_cnt = 8'd0;
            n_row_cnt = r_row_cnt + 8'd1;
        end else begin
            n_col_cnt = r_col_cnt + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= clb_pkg::C_BASE_RESET;
            r_col_cnt <= 8'd0;
            r_row_cnt <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_adv) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
            end
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && rect_end) |=> (r_col_cnt == 8'd0 && r_row_cnt == 8'd0))
        else $error("counters not cleared after last beat");

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.write_enable |-> (o_res.address == 16'd0 && o_res.write_data == 8'd0))
        else $error("clipped beat carries nonzero payload");

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !row_end) |=> (r_col_cnt == $past(r_col_cnt) + 8'd1))
        else $error("column counter did not advance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_adv && !i_cfg_we) |=> ($stable(r_col_cnt) && $stable(r_row_cnt)))
        else $error("counters moved without a beat");

endmodule

FILE: sv/clb_out_stage.sv
// ----------------------------------------------------------------------------
// clb_out_stage
// Result register: holds one finished beat until the sink takes it.
// ----------------------------------------------------------------------------
module clb_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  clb_pkg::t_res i_res,
    input  logic          i_stall,
    output logic          o_take,
    output logic          o_valid,
    output clb_pkg::t_res o_res
);

    logic          r_vld;
    logic          n_vld;
    clb_pkg::t_res r_res;

    assign o_take = i_vld && (!r_vld || !i_stall);
    assign n_vld  = o_take || (r_vld && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

FILE: sv/clipped_interleaved_blit_core.sv
// ----------------------------------------------------------------------------
// clipped_interleaved_blit_core
// Path: an accepted input beat is held in the input register, and its result in the result register.
// Throughput: one beat per cycle while the sink does not stall, set by the input and result registers.
// Reset: synchronous active low; counters clear, screen base to 0x4000.
// ----------------------------------------------------------------------------
module clipped_interleaved_blit_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic signed [7:0] i_col,
    input  logic [7:0]        i_top_line,
    input  logic [7:0]        i_width,
    input  logic [7:0]        i_height,
    input  logic [7:0]        i_source_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_write_enable,
    output logic [15:0]       o_address,
    output logic [7:0]        o_write_data,
    output logic              o_last
);

    clb_pkg::t_cmd in_cmd;
    clb_pkg::t_cmd s1_cmd;
    clb_pkg::t_res calc_res;
    clb_pkg::t_res out_res;
    logic          s1_vld;
    logic          take;

    always_comb begin
        in_cmd.func        = i_func;
        in_cmd.col         = i_col;
        in_cmd.top_line    = i_top_line;
        in_cmd.width       = i_width;
        in_cmd.height      = i_height;
        in_cmd.source_byte = i_source_byte;
    end

    clb_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (in_cmd),
        .i_take  (take),
        .o_stall (o_stall),
        .o_vld   (s1_vld),
        .o_cmd   (s1_cmd)
    );

    clb_calc u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_adv      (take),
        .i_cmd      (s1_cmd),
        .o_res      (calc_res)
    );

    clb_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s1_vld),
        .i_res   (calc_res),
        .i_stall (i_stall),
        .o_take  (take),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_write_enable = out_res.write_enable;
    assign o_address      = out_res.address;
    assign o_write_data   = out_res.write_data;
    assign o_last         = out_res.last;

endmodule

FILE: tb/tb_clipped_interleaved_blit_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clipped_interleaved_blit_core
// Self-checking bench for the clipped interleaved blit core. Sprite beats are
// sent as whole rectangles and as stray beats. A model of the column and row
// counters predicts every write beat: the clip decision, the interleaved
// address, the data and the last flag. Both sides idle in random bursts, the
// receiver holds off once for a long stretch, and the screen base is moved
// between phases.
// ----------------------------------------------------------------------------
module tb_clipped_interleaved_blit_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int RANDOM_BEATS   = 260;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [15:0]       i_cfg_data    = '0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic              i_func        = 1'b0;
    logic signed [7:0] i_col         = '0;
    logic [7:0]        i_top_line    = '0;
    logic [7:0]        i_width       = 8'd1;
    logic [7:0]        i_height      = 8'd1;
    logic [7:0]        i_source_byte = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic              o_write_enable;
    logic [15:0]       o_address;
    logic [7:0]        o_write_data;
    logic              o_last;

    logic [15:0]   base_model   = clb_pkg::C_BASE_RESET;
    logic [7:0]    source_col   = '0;
    logic [7:0]    source_row   = '0;
    clb_pkg::t_res pending_writes[$];
    int            errors       = 0;
    int            idle_cycles  = 0;
    int            hold_len     = 0;
    bit            gap_on       = 1'b0;
    bit            stall_on     = 1'b0;

    always #5 i_clk = ~i_clk;

    clipped_interleaved_blit_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_col          (i_col),
        .i_top_line     (i_top_line),
        .i_width        (i_width),
        .i_height       (i_height),
        .i_source_byte  (i_source_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_enable (o_write_enable),
        .o_address      (o_address),
        .o_write_data   (o_write_data),
        .o_last         (o_last)
    );

    task automatic predict_write(input clb_pkg::t_cmd c);
        int            scr_col;
        logic [7:0]    line;
        logic [12:0]   offset;
        logic          visible;
        logic          row_end;
        logic          rect_end;
        clb_pkg::t_res r;
        scr_col  = int'($signed(c.col)) + int'(source_col);
        line     = c.top_line + source_row;
        visible  = scr_col >= 0 && scr_col < int'(clb_pkg::C_SCREEN_COLUMNS) &&
                   line < clb_pkg::C_SCREEN_LINES;
        row_end  = int'(source_col) + 1 >= int'(c.width);
        rect_end = row_end && int'(source_row) + 1 >= int'(c.height);
        offset   = {line[7:6], line[2:0], line[5:3], 5'(scr_col)};
        r = '0;
        if (visible) begin
            r.write_enable = 1'b1;
            r.address      = base_model + 16'(offset);
            r.write_data   = c.func ? 8'h00 : c.source_byte;
        end
        r.last = rect_end;
        pending_writes.push_back(r);
        if (rect_end) begin
            source_col = '0;
            source_row = '0;
        end else if (row_end) begin
            source_col = '0;
            source_row = source_row + 8'd1;
        end else begin
            source_col = source_col + 8'd1;
        end
    endtask

    task automatic send_beat(input clb_pkg::t_cmd c);
        int gap;
        if (gap_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_func        <= c.func;
        i_col         <= c.col;
        i_top_line    <= c.top_line;
        i_width       <= c.width;
        i_height      <= c.height;
        i_source_byte <= c.source_byte;
        do @(posedge i_clk); while (o_stall);
        predict_write(c);
    endtask

    task automatic send_beats(input logic func, input logic [7:0] col,
                              input logic [7:0] top, input logic [7:0] w,
                              input logic [7:0] h, input int n);
        clb_pkg::t_cmd c;
        for (int k = 0; k < n; k++) begin
            c.func        = func;
            c.col         = col;
            c.top_line    = top;
            c.width       = w;
            c.height      = h;
            c.source_byte = 8'($urandom);
            send_beat(c);
        end
    endtask

    task automatic send_rect(input logic func, input logic [7:0] col,
                             input logic [7:0] top, input logic [7:0] w,
                             input logic [7:0] h);
        int n;
        n = (w == 0 ? 1 : int'(w)) * (h == 0 ? 1 : int'(h));
        send_beats(func, col, top, w, h, n);
    endtask

    task automatic wait_idle;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_screen_base(input logic [15:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        base_model = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed_cases;
        gap_on   = 1'b1;
        stall_on = 1'b1;
        send_rect(1'b0, -8'sd1, 8'd190, 8'd3, 8'd3);
        send_rect(1'b0, 8'd30, 8'd255, 8'd3, 8'd2);
        send_beat('{func: 1'b0, col: 8'sd0, top_line: 8'd0, width: 8'd0,
                    height: 8'd0, source_byte: 8'hFF});
        send_beat('{func: 1'b0, col: 8'sd31, top_line: 8'd191, width: 8'd1,
                    height: 8'd1, source_byte: 8'h00});
        send_rect(1'b1, 8'sd127, 8'd10, 8'd1, 8'd1);
        send_rect(1'b1, -8'sd128, 8'd10, 8'd1, 8'd1);
        // shrink the width mid-row: the column count is past it
        send_beats(1'b0, 8'd5, 8'd100, 8'd4, 8'd2, 3);
        send_beats(1'b0, 8'd5, 8'd100, 8'd1, 8'd2, 2);
        wait_idle();
    endtask

    task automatic test_screen_base;
        logic [15:0] bases[4];
        bases = '{16'h0000, 16'hFFFF, 16'($urandom), 16'hC000};
        foreach (bases[k]) begin
            write_screen_base(bases[k]);
            send_rect(1'(k), 8'($urandom_range(0, 4) - 2), 8'(k * 64 + 60), 8'd5, 8'd3);
        end
    endtask

    task automatic test_random_rects;
        int         sent;
        logic [7:0] col;
        logic [7:0] top;
        logic [7:0] w;
        logic [7:0] h;
        gap_on   = 1'b1;
        stall_on = 1'b1;
        write_screen_base(16'($urandom));
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beats(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 1);
                sent++;
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    w = 8'($urandom_range(9, 40));
                    h = 8'($urandom_range(1, 2));
                end else begin
                    w = 8'($urandom_range(1, 6));
                    h = 8'($urandom_range(1, 5));
                end
                col = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 44) - 8);
                top = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(176, 255))
                                                  : 8'($urandom);
                send_rect(1'($urandom_range(0, 3) == 0), col, top, w, h);
                sent += int'(w) * int'(h);
            end
            if (sent > RANDOM_BEATS / 2 && sent < RANDOM_BEATS / 2 + 8) begin
                write_screen_base(16'($urandom));
            end
        end
        wait_idle();
    endtask

    task automatic test_backpressure;
        gap_on   = 1'b0;
        stall_on = 1'b0;
        hold_len = HOLD_CYCLES;
        send_rect(1'b0, -8'sd3, 8'd185, 8'd10, 8'd6);
        wait_idle();
    endtask

    task automatic test_no_idle;
        gap_on   = 1'b0;
        stall_on = 1'b0;
        write_screen_base(clb_pkg::C_BASE_RESET);
        send_rect(1'b0, 8'd28, 8'd60, 8'd8, 8'd4);
        send_rect(1'b1, -8'sd2, 8'd188, 8'd4, 8'd3);
        send_rect(1'b0, 8'd0, 8'd0, 8'd6, 8'd2);
        wait_idle();
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_stall <= 1'b1;
                repeat (hold_len - 1) @(negedge i_clk);
                hold_len = 0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        clb_pkg::t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual we=%0b addr=0x%0h",
                         $time, o_write_enable, o_address);
            end else begin
                want = pending_writes.pop_front();
                if (want.write_enable !== o_write_enable)
                    report_mismatch("write_enable", 16'(want.write_enable), 16'(o_write_enable));
                if (want.address !== o_address)
                    report_mismatch("address", want.address, o_address);
                if (want.write_data !== o_write_data)
                    report_mismatch("write_data", 16'(want.write_data), 16'(o_write_data));
                if (want.last !== o_last)
                    report_mismatch("last", 16'(want.last), 16'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_clipped_interleaved_blit_core failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_screen_base();
        test_random_rects();
        test_backpressure();
        test_no_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_writes.size() == 0) begin
            $display("tb_clipped_interleaved_blit_core passed");
        end else begin
            $display("tb_clipped_interleaved_blit_core failed");
        end
        $finish;
    end

endmodule
